// ----- rtl/core/pfr_pkg.sv -----
package pfr_pkg;

   localparam int ADDR_W   = 20;
   localparam int PAGE_W   = 14;
   localparam int OFFSET_W = 7;
   localparam int FRAME_W  = 3;
   localparam int TIME_W   = 16;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              start_run;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]   page_number;
      logic [OFFSET_W-1:0] page_offset;
      logic                hit;
      logic                replaced;
      logic [FRAME_W-1:0]  frame_index;
      logic [TIME_W-1:0]   fault_count;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [TIME_W-1:0] load_time;
      logic [TIME_W-1:0] use_time;
   } frame_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOTIENT,
      ST_PRODUCT,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic quotient;
      logic product;
      logic scan_step;
      logic commit;
   } pfr_cmd_type;

   typedef struct packed {
      logic scan_last;
   } pfr_status_type;

endpackage

// ----- rtl/core/pfr_ctrl.sv -----
module pfr_ctrl
   import pfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pfr_status_type status,
   output pfr_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_QUOTIENT;
         end
         ST_QUOTIENT: state_in = ST_PRODUCT;
         ST_PRODUCT:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_QUOTIENT: cmd.quotient  = 1'b1;
         ST_PRODUCT:  cmd.product   = 1'b1;
         ST_SCAN:     cmd.scan_step = 1'b1;
         ST_COMMIT:   cmd.commit    = out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/pfr_datapath.sv -----
module pfr_datapath
   import pfr_pkg::*;
#(
   parameter int FRAME_COUNT = 5,
   parameter int PAGE_BYTES  = 100
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_en,
   input  logic           csr_write_data,
   input  req_type        req_data,
   input  pfr_cmd_type    cmd,
   output pfr_status_type status,
   output rsp_type        rsp_data
);

   localparam int IDX_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int FILL_W    = $clog2(FRAME_COUNT + 1);
   localparam int DIV_LOG   = $clog2(PAGE_BYTES);
   localparam int DIV_SHIFT = ADDR_W + DIV_LOG;
   localparam int RECIP_W   = 22;
   localparam int DIVC_W    = 17;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
   localparam logic [RECIP_W-1:0] RECIP  = RECIP_FULL[RECIP_W-1:0];
   localparam logic [DIVC_W-1:0]  DIVC   = DIVC_W'(PAGE_BYTES);
   localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(FRAME_COUNT);
   localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(FRAME_COUNT - 1);

   // Run state and mode.
   logic              mode_ff;
   logic [FILL_W-1:0] filled_ff, filled_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] faults_ff, faults_in;

   // Arithmetic for the page split.
   logic [ADDR_W-1:0]         addr_ff;
   logic [ADDR_W-1:0]         quot_ff;
   logic [ADDR_W-1:0]         qd_ff;
   logic [ADDR_W+RECIP_W-1:0] recip_prod;
   logic [ADDR_W+DIVC_W-1:0]  qd_prod;
   logic [ADDR_W-1:0]         offset;

   // Table scan.
   frame_entry_type   table_ff [FRAME_COUNT];
   frame_entry_type   entry;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [TIME_W-1:0] best_stamp_ff;
   logic [TIME_W-1:0] stamp;
   logic              entry_used;

   // Commit.
   logic                full;
   logic [IDX_W-1:0]    win_idx;
   logic [IDX_W+2:0]    win_ext;
   frame_entry_type     new_entry;
   rsp_type             rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   // The reciprocal is rounded up with enough fraction bits that the
   // quotient is exact for every 20-bit address.
   assign recip_prod = (ADDR_W+RECIP_W)'(addr_ff) * (ADDR_W+RECIP_W)'(RECIP);
   assign qd_prod    = (ADDR_W+DIVC_W)'(quot_ff) * (ADDR_W+DIVC_W)'(DIVC);
   assign offset     = addr_ff - qd_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture)  addr_ff <= req_data.address;
      if (cmd.quotient) quot_ff <= ADDR_W'(recip_prod >> DIV_SHIFT);
      if (cmd.product)  qd_ff   <= qd_prod[ADDR_W-1:0];
   end

   assign entry      = table_ff[scan_idx_ff];
   assign stamp      = mode_ff ? entry.use_time : entry.load_time;
   assign entry_used = FILL_W'(scan_idx_ff) < filled_ff;
   assign status.scan_last = scan_idx_ff == IDX_LAST;

   always_ff @(posedge clock) begin
      if (cmd.product) begin
         scan_idx_ff <= '0;
         hit_ff      <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (!hit_ff && entry_used && entry.page == quot_ff[PAGE_W-1:0]) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= scan_idx_ff;
         end
         // Strict compare keeps the lowest index on equal stamps.
         if (scan_idx_ff == '0 || stamp < best_stamp_ff) begin
            best_idx_ff   <= scan_idx_ff;
            best_stamp_ff <= stamp;
         end
      end
   end

   assign full = filled_ff == FILL_MAX;

   always_comb begin
      if (hit_ff) begin
         win_idx = hit_idx_ff;
      end else if (full) begin
         win_idx = best_idx_ff;
      end else begin
         win_idx = filled_ff[IDX_W-1:0];
      end
      win_ext = {3'b000, win_idx};

      new_entry           = table_ff[win_idx];
      new_entry.use_time  = time_ff;
      if (!hit_ff) begin
         new_entry.page      = quot_ff[PAGE_W-1:0];
         new_entry.load_time = time_ff;
      end
   end

   always_comb begin
      filled_in = filled_ff;
      time_in   = time_ff;
      faults_in = faults_ff;
      if (cmd.capture && req_data.start_run) begin
         filled_in = '0;
         time_in   = '0;
         faults_in = '0;
      end else if (cmd.commit) begin
         if (!hit_ff && !full) filled_in = filled_ff + 1'b1;
         if (!hit_ff && full && faults_ff != TIME_MAX) faults_in = faults_ff + 1'b1;
         if (time_ff != TIME_MAX) time_in = time_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in.page_number = quot_ff[PAGE_W-1:0];
      rsp_in.page_offset = offset[OFFSET_W-1:0];
      rsp_in.hit         = hit_ff;
      rsp_in.replaced    = !hit_ff && full;
      rsp_in.frame_index = win_ext[FRAME_W-1:0];
      rsp_in.fault_count = faults_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         time_ff   <= '0;
         faults_ff <= '0;
      end else begin
         filled_ff <= filled_in;
         time_ff   <= time_in;
         faults_ff <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         table_ff[win_idx] <= new_entry;
         rsp_ff            <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/page_frame_replacement.sv -----
// Page-frame replacement engine. Each request transaction carries a byte
// address, which is split into a page number and an offset by the page size,
// and the page is looked up in a table of FRAME_COUNT frames. A hit refreshes
// the frame's last-use time, a miss fills the next free frame, and once the
// table is full a miss evicts the oldest-loaded frame (csr_write_data = 0) or
// the least recently used frame (csr_write_data = 1), lowest index on ties;
// only evictions count as faults. Setting start_run clears the table, the
// reference time and the fault count before that reference. The result of a
// transaction is valid once the reciprocal multiply and back-multiply that
// split the address, the table scan over every frame in turn and a commit
// have run; the commit waits while an earlier result is still unaccepted.
// The block then returns to idle, so it takes no new request before it is
// through with the last one. The result sits in an output register, so the
// next request is taken while it waits. Write the mode only while idle.
module page_frame_replacement
   import pfr_pkg::*;
#(
   parameter int FRAME_COUNT = 5,
   parameter int PAGE_BYTES  = 100
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write_en,
   input  logic    csr_write_data
);

   pfr_cmd_type    cmd;
   pfr_status_type status;

   pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfr_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_data       (rsp_data)
   );

endmodule

// ----- tb/tb_page_frame_replacement.sv -----
module tb_page_frame_replacement;
   import pfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_COUNT   = 5;
   localparam int PAGE_BYTES    = 100;
   localparam int SETTLE_CYCLES = FRAME_COUNT + 8;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int HOLD_CYCLES   = 150;

   // Tracks the frame table, reference time and fault count of the block and
   // keeps the results that accepted transactions still owe.
   class frame_table_tracker;
      logic [PAGE_W-1:0] resident_page [FRAME_COUNT];
      logic [TIME_W-1:0] loaded_at [FRAME_COUNT];
      logic [TIME_W-1:0] used_at [FRAME_COUNT];
      int unsigned       frames_in_use;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] evictions;
      logic              lru_mode;
      rsp_type           awaited [$];
      int unsigned       failures;
      int unsigned       results_seen;

      function new();
         lru_mode = 1'b0;
         failures = 0;
         results_seen = 0;
         clear_run();
      endfunction

      function void clear_run();
         for (int i = 0; i < FRAME_COUNT; i++) begin
            resident_page[i] = '0;
            loaded_at[i] = '0;
            used_at[i] = '0;
         end
         frames_in_use = 0;
         stamp = '0;
         evictions = '0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void take_reference(req_type r);
         int unsigned page;
         int unsigned offset;
         int unsigned slot;
         logic        hit;
         logic        evicted;
         rsp_type     e;
         if (r.start_run) clear_run();
         page = (r.address / PAGE_BYTES) % (1 << PAGE_W);
         offset = r.address % PAGE_BYTES;
         hit = 1'b0;
         evicted = 1'b0;
         slot = 0;
         for (int i = 0; i < frames_in_use; i++) begin
            if (!hit && resident_page[i] == PAGE_W'(page)) begin
               hit = 1'b1;
               slot = i;
            end
         end
         if (hit) begin
            used_at[slot] = stamp;
         end else begin
            if (frames_in_use < FRAME_COUNT) begin
               slot = frames_in_use;
               frames_in_use++;
            end else begin
               // Strictly smaller stamp wins, so ties stay with the lower frame.
               slot = 0;
               for (int i = 1; i < FRAME_COUNT; i++) begin
                  if (lru_mode ? (used_at[i] < used_at[slot])
                               : (loaded_at[i] < loaded_at[slot]))
                     slot = i;
               end
               evicted = 1'b1;
               if (evictions != TIME_MAX) evictions++;
            end
            resident_page[slot] = PAGE_W'(page);
            loaded_at[slot] = stamp;
            used_at[slot] = stamp;
         end
         if (stamp != TIME_MAX) stamp++;
         e.page_number = PAGE_W'(page);
         e.page_offset = OFFSET_W'(offset);
         e.hit = hit;
         e.replaced = evicted;
         e.frame_index = FRAME_W'(slot);
         e.fault_count = evictions;
         awaited.push_back(e);
      endfunction

      function void check_outcome(rsp_type got);
         rsp_type e;
         results_seen++;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result %0d arrived with no reference pending: page %0d offset %0d",
                        results_seen, got.page_number, got.page_offset);
         end else begin
            e = awaited.pop_front();
            if (got.page_number !== e.page_number || got.page_offset !== e.page_offset ||
                got.hit !== e.hit || got.replaced !== e.replaced ||
                got.frame_index !== e.frame_index || got.fault_count !== e.fault_count) begin
               failures++;
               if (failures <= 10) begin
                  $display("result %0d mismatch", results_seen);
                  $display("  expected page %0d offset %0d hit %0d replaced %0d",
                           e.page_number, e.page_offset, e.hit, e.replaced);
                  $display("           frame %0d faults %0d",
                           e.frame_index, e.fault_count);
                  $display("  actual   page %0d offset %0d hit %0d replaced %0d",
                           got.page_number, got.page_offset, got.hit, got.replaced);
                  $display("           frame %0d faults %0d",
                           got.frame_index, got.fault_count);
               end
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en = 1'b0;
   logic    csr_write_data = 1'b0;

   frame_table_tracker tracker;
   int unsigned        burst_left = 0;

   page_frame_replacement #(
      .FRAME_COUNT(FRAME_COUNT),
      .PAGE_BYTES (PAGE_BYTES)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one reference and holds it until the block takes it. The sender
   // runs in bursts; a gap drops valid right after the accepting edge.
   task automatic issue(input logic [ADDR_W-1:0] addr, input logic start);
      req_type r;
      int      gap;
      r.address = addr;
      r.start_run = start;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_reference(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic lru);
      csr_write_en <= 1'b1;
      csr_write_data <= lru;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.lru_mode = lru;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_outcome(rsp_data);
   end

   // Result side pacing: segments of random length, each with its own
   // acceptance density, plus long hold-offs that back the block up.
   initial begin : rsp_pacing
      int          seg;
      int          style;
      int          held;
      int unsigned hold_at;
      hold_at = 150;
      while (reset) @(posedge clock);
      forever begin
         if (tracker.results_seen >= hold_at && hold_at < 1000) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_at += 600;
         end
         style = $urandom_range(0, 3);
         seg = $urandom_range(4, 40);
         repeat (seg) begin
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned pool [10];
      int          pool_size;
      int          seq_len;
      int          seq_count;
      logic        mode_next;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Oldest-loaded replacement on a short hand-built stream.
      write_mode(1'b0);
      issue(20'd0, 1'b1);
      issue(20'd99, 1'b0);          // same page, largest offset
      issue(20'hFFFFF, 1'b0);       // highest page
      issue(20'd100, 1'b0);
      issue(20'd250, 1'b0);
      issue(20'd399, 1'b0);         // table now full
      issue(20'd450, 1'b0);         // first eviction
      issue(20'd1048525, 1'b0);     // hit on the highest page
      issue(20'd500, 1'b0);         // evicts by load order despite the recent use
      issue(20'd0, 1'b0);
      wait_idle();

      // Least recently used, then a fresh run on a page that was resident.
      write_mode(1'b1);
      issue(20'd1000, 1'b1);
      issue(20'd1100, 1'b0);
      issue(20'd1200, 1'b0);
      issue(20'd1300, 1'b0);
      issue(20'd1400, 1'b0);
      issue(20'd1050, 1'b0);
      issue(20'd1500, 1'b0);
      issue(20'd1199, 1'b0);
      issue(20'd1300, 1'b0);
      issue(20'd1600, 1'b0);
      issue(20'd1000, 1'b1);
      wait_idle();

      // Random streams over small page pools so hits and evictions both occur.
      sent = 0;
      mode_next = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         write_mode(mode_next);
         mode_next = ~mode_next;
         seq_count = $urandom_range(3, 6);
         repeat (seq_count) begin
            pool_size = $urandom_range(2, 9);
            for (int k = 0; k < pool_size; k++) pool[k] = $urandom_range(0, 10484);
            seq_len = $urandom_range(4, 60);
            for (int n = 0; n < seq_len; n++) begin
               if ($urandom_range(0, 9) == 0)
                  issue(ADDR_W'($urandom_range(0, 20'hFFFFF)), $urandom_range(0, 7) == 0);
               else
                  issue(ADDR_W'(pool[$urandom_range(0, pool_size - 1)] * PAGE_BYTES
                                + $urandom_range(0, PAGE_BYTES - 1)),
                        n == 0 && $urandom_range(0, 9) != 0);
               sent++;
            end
         end
         wait_idle();
      end

      if (tracker.failures == 0)
         $display("tb_page_frame_replacement: clean");
      else
         $display("tb_page_frame_replacement: errors");
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("tb_page_frame_replacement: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pfr_pkg.sv
rtl/core/pfr_ctrl.sv
rtl/core/pfr_datapath.sv
rtl/core/page_frame_replacement.sv
tb/tb_page_frame_replacement.sv
